// ----- src/bsi_pkg.sv -----
// Package for the bounded sorted insertion list.
// Holds the command codes, field widths and stream packing widths.
// No dependencies; used by the top level.
package bsi_pkg;

    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_READ   = 1'b1;

    localparam int KEY_FIELD_W     = 32;
    localparam int PAYLOAD_FIELD_W = 32;
    localparam int INDEX_FIELD_W   = 4;
    localparam int POS_FIELD_W     = 4;
    localparam int COUNT_FIELD_W   = 5;
    localparam int LIMIT_W         = 5;

    localparam int CFG_INDEX_W = 1;
    localparam logic [CFG_INDEX_W-1:0] CFG_LIMIT      = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] CFG_KEY_SIGNED = 1'b1;

    localparam int S_TDATA_W = 72;
    localparam int M_TDATA_W = 80;

endpackage

// ----- src/bsi_ram.sv -----
// Simple dual-port entry memory for the bounded sorted insertion list.
// One write port and one read port with registered read data.
// No package dependencies; instantiated by the top level.
module bsi_ram #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 64
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- src/bounded_sorted_insert.sv -----
// Bounded sorted insertion list: top level with control sequencer.
// Depends on bsi_pkg and on bsi_ram, which holds the key and payload entries.
//
// Requests arrive on s_axis; s_axis_tuser selects insert or read. Each request
// produces exactly one result on m_axis. Configuration (limit, key_signed) is
// written through cfg_valid/cfg_ready/cfg_index/cfg_data, one register per request.
// Requests are handled one at a time. An insert walks the list downwards from
// the last slot, one entry per cycle through the memory's read port, shifting
// larger entries up as it goes. An insert into an empty list writes the entry
// directly; an insert into a full list first compares with the last entry and
// is refused if the new key is larger, else evicts it. The sequencer returns
// to idle at the same edge that loads the result into the output register,
// so the next request can be taken while the result still waits for
// m_axis_tready.
// If the receiver stalls with a result still held, the next result waits in
// the sequencer and s_axis_tready stays low until the output register frees.
// Reset empties the list (count zero), sets limit to 16 and unsigned compare.
// Memory contents are not cleared; only entries below the count are ever used.
module bounded_sorted_insert #(
    parameter int CAPACITY      = 16,
    parameter int KEY_WIDTH     = 32,
    parameter int PAYLOAD_WIDTH = 32
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // key [31:0], payload [63:32], read_index [67:64], zeros [71:68]
    input  logic [bsi_pkg::S_TDATA_W-1:0]      s_axis_tdata,
    // command [0]
    input  logic                               s_axis_tuser,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // accepted [0], position [4:1], evicted [5], count [10:6], read_valid [11],
    // read_key [43:12], read_payload [75:44], zeros [79:76]
    output logic [bsi_pkg::M_TDATA_W-1:0]      m_axis_tdata,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [bsi_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [bsi_pkg::LIMIT_W-1:0]        cfg_data
);

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int EW = KEY_WIDTH + PAYLOAD_WIDTH;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_LOOK  = 3'd1;
    localparam logic [2:0] ST_CMP   = 3'd2;
    localparam logic [2:0] ST_PLACE = 3'd3;
    localparam logic [2:0] ST_RD    = 3'd4;
    localparam logic [2:0] ST_DONE  = 3'd5;

    logic [2:0]                   state_reg, state_next;
    logic [bsi_pkg::LIMIT_W-1:0]  limit_reg, limit_next;
    logic                         key_signed_reg, key_signed_next;
    logic [CW-1:0]                count_reg, count_next;
    logic [CW-1:0]                lim_reg, lim_next;
    logic                         full_reg, full_next;
    logic [AW-1:0]                slot_reg, slot_next;
    logic [KEY_WIDTH-1:0]         key_reg, key_next;
    logic [PAYLOAD_WIDTH-1:0]     pay_reg, pay_next;

    logic                                 res_acc_reg, res_acc_next;
    logic                                 res_evi_reg, res_evi_next;
    logic                                 res_rv_reg, res_rv_next;
    logic [bsi_pkg::KEY_FIELD_W-1:0]      res_key_reg, res_key_next;
    logic [bsi_pkg::PAYLOAD_FIELD_W-1:0]  res_pay_reg, res_pay_next;

    logic                           m_valid_reg, m_valid_next;
    logic [bsi_pkg::M_TDATA_W-1:0]  m_data_reg, m_data_next;

    logic                 wr_en;
    logic [AW-1:0]        wr_addr;
    logic [EW-1:0]        wr_data;
    logic [AW-1:0]        rd_addr;
    logic [EW-1:0]        rd_data;

    logic [bsi_pkg::KEY_FIELD_W-1:0]     in_key;
    logic [bsi_pkg::PAYLOAD_FIELD_W-1:0] in_pay;
    logic [bsi_pkg::INDEX_FIELD_W-1:0]   in_idx;
    logic [KEY_WIDTH-1:0]                ord_mask;
    logic [KEY_WIDTH-1:0]                ko;
    logic [KEY_WIDTH-1:0]                mem_key;
    logic [PAYLOAD_WIDTH-1:0]            mem_pay;
    logic [KEY_WIDTH-1:0]                mem_ko;
    logic [CW-1:0]                       eff_lim;
    logic                                in_full;
    logic                                out_free;

    assign in_key = s_axis_tdata[31:0];
    assign in_pay = s_axis_tdata[63:32];
    assign in_idx = s_axis_tdata[67:64];

    assign ord_mask = KEY_WIDTH'(key_signed_reg) << (KEY_WIDTH - 1);
    assign ko       = key_reg ^ ord_mask;
    assign mem_key  = rd_data[EW-1:PAYLOAD_WIDTH];
    assign mem_pay  = rd_data[PAYLOAD_WIDTH-1:0];
    assign mem_ko   = mem_key ^ ord_mask;

    always_comb begin
        if (limit_reg == '0) begin
            eff_lim = CW'(1);
        end else if (32'(limit_reg) > 32'(CAPACITY)) begin
            eff_lim = CW'(CAPACITY);
        end else begin
            eff_lim = CW'(limit_reg);
        end
    end

    assign in_full  = count_reg >= eff_lim;
    assign out_free = !m_valid_reg || m_axis_tready;

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign cfg_ready     = 1'b1;
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;

    always_comb begin
        state_next      = state_reg;
        limit_next      = limit_reg;
        key_signed_next = key_signed_reg;
        count_next      = count_reg;
        lim_next        = lim_reg;
        full_next       = full_reg;
        slot_next       = slot_reg;
        key_next        = key_reg;
        pay_next        = pay_reg;
        res_acc_next    = res_acc_reg;
        res_evi_next    = res_evi_reg;
        res_rv_next     = res_rv_reg;
        res_key_next    = res_key_reg;
        res_pay_next    = res_pay_reg;
        m_valid_next    = m_valid_reg;
        m_data_next     = m_data_reg;
        wr_en           = 1'b0;
        wr_addr         = slot_reg;
        wr_data         = {key_reg, pay_reg};
        rd_addr         = slot_reg - AW'(1);

        if (m_valid_reg && m_axis_tready) begin
            m_valid_next = 1'b0;
        end

        if (cfg_valid) begin
            case (cfg_index)
                bsi_pkg::CFG_LIMIT:      limit_next = cfg_data;
                bsi_pkg::CFG_KEY_SIGNED: key_signed_next = cfg_data[0];
                default: ;
            endcase
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_axis_tvalid) begin
                    key_next     = KEY_WIDTH'(in_key);
                    pay_next     = PAYLOAD_WIDTH'(in_pay);
                    lim_next     = eff_lim;
                    full_next    = in_full;
                    res_acc_next = 1'b0;
                    res_evi_next = 1'b0;
                    res_rv_next  = 1'b0;
                    res_key_next = '0;
                    res_pay_next = '0;
                    if (s_axis_tuser == bsi_pkg::CMD_READ) begin
                        rd_addr     = AW'(in_idx);
                        res_rv_next = (32'(in_idx) < 32'(count_reg))
                                   && (32'(in_idx) < 32'(CAPACITY));
                        state_next  = ST_RD;
                    end else if (in_full) begin
                        slot_next  = AW'(eff_lim - CW'(1));
                        rd_addr    = AW'(eff_lim - CW'(1));
                        state_next = ST_LOOK;
                    end else if (count_reg == '0) begin
                        wr_en        = 1'b1;
                        wr_addr      = '0;
                        wr_data      = {KEY_WIDTH'(in_key), PAYLOAD_WIDTH'(in_pay)};
                        slot_next    = '0;
                        res_acc_next = 1'b1;
                        count_next   = count_reg + CW'(1);
                        state_next   = ST_DONE;
                    end else begin
                        slot_next  = AW'(count_reg);
                        rd_addr    = AW'(count_reg - CW'(1));
                        state_next = ST_CMP;
                    end
                end
            end
            ST_LOOK: begin
                if (ko <= mem_ko) begin
                    res_acc_next = 1'b1;
                    res_evi_next = 1'b1;
                    if (slot_reg == '0) begin
                        state_next = ST_PLACE;
                    end else begin
                        rd_addr    = slot_reg - AW'(1);
                        state_next = ST_CMP;
                    end
                end else begin
                    state_next = ST_DONE;
                end
            end
            ST_CMP: begin
                if (ko < mem_ko) begin
                    wr_en     = 1'b1;
                    wr_addr   = slot_reg;
                    wr_data   = rd_data;
                    slot_next = slot_reg - AW'(1);
                    if (slot_reg == AW'(1)) begin
                        state_next = ST_PLACE;
                    end else begin
                        rd_addr = slot_reg - AW'(2);
                    end
                end else begin
                    wr_en        = 1'b1;
                    res_acc_next = 1'b1;
                    count_next   = full_reg ? lim_reg : count_reg + CW'(1);
                    state_next   = ST_DONE;
                end
            end
            ST_PLACE: begin
                wr_en        = 1'b1;
                res_acc_next = 1'b1;
                count_next   = full_reg ? lim_reg : count_reg + CW'(1);
                state_next   = ST_DONE;
            end
            ST_RD: begin
                if (res_rv_reg) begin
                    res_key_next = bsi_pkg::KEY_FIELD_W'(mem_key);
                    res_pay_next = bsi_pkg::PAYLOAD_FIELD_W'(mem_pay);
                end
                state_next = ST_DONE;
            end
            ST_DONE: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_data_next  = {4'b0000,
                                    res_pay_reg,
                                    res_key_reg,
                                    res_rv_reg,
                                    bsi_pkg::COUNT_FIELD_W'(count_reg),
                                    res_evi_reg,
                                    res_acc_reg ? bsi_pkg::POS_FIELD_W'(slot_reg)
                                                : {bsi_pkg::POS_FIELD_W{1'b0}},
                                    res_acc_reg};
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            limit_reg      <= bsi_pkg::LIMIT_W'(16);
            key_signed_reg <= 1'b0;
            count_reg      <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            limit_reg      <= limit_next;
            key_signed_reg <= key_signed_next;
            count_reg      <= count_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        lim_reg     <= lim_next;
        full_reg    <= full_next;
        slot_reg    <= slot_next;
        key_reg     <= key_next;
        pay_reg     <= pay_next;
        res_acc_reg <= res_acc_next;
        res_evi_reg <= res_evi_next;
        res_rv_reg  <= res_rv_next;
        res_key_reg <= res_key_next;
        res_pay_reg <= res_pay_next;
        m_data_reg  <= m_data_next;
    end

    bsi_ram #(
        .DEPTH (CAPACITY),
        .WIDTH (EW)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

endmodule
